>>> rtl/core/lssc_pkg.sv
// ----------------------------------------------------------------------------
// Lane segment slope classifier package
// Shared widths, codes and types for the front, back and top level.
// ----------------------------------------------------------------------------
package lssc_pkg;

   // Geometry and number format.
   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;
   localparam int MAX_LINES  = 128;
   localparam int CNT_W      = $clog2(MAX_LINES + 1);

   // Field widths of the ports.
   localparam int REG_W   = 21;
   localparam int SIDE_W  = 2;
   localparam int SLOPE_W = 19;
   localparam int ICPT_W  = 29;
   localparam int SLOT_W  = 7;

   // Register port.
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic REG_SLOPE_MIN = 1'b0;
   localparam logic REG_SLOPE_MAX = 1'b1;
   localparam logic [REG_W-1:0] SLOPE_MIN_RESET = REG_W'(13107);
   localparam logic [REG_W-1:0] SLOPE_MAX_RESET = REG_W'(131072);

   // Divider and datapath widths.
   localparam int DIV_W       = COORD_BITS + FRAC_BITS;
   localparam int STEP_W      = $clog2(DIV_W);
   localparam int K_W         = REG_W + 1;
   localparam int PROD_W      = K_W + COORD_BITS + 1;
   localparam int ICPT_CALC_W = PROD_W + 1;

   // Queue between front and back.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [SIDE_W-1:0] {
      SIDE_REJECT = 2'd0,
      SIDE_LEFT   = 2'd1,
      SIDE_RIGHT  = 2'd2
   } side_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_MUL,
      BK_FIN
   } back_state_type;

   // One segment after the front has taken it apart.
   typedef struct packed {
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] adx;
      logic [COORD_BITS-1:0] ady;
      logic                  neg;
      logic                  vertical;
      logic                  frame_start;
   } seg_type;

   // Slope window from the register port.
   typedef struct packed {
      logic [REG_W-1:0] slope_min;
      logic [REG_W-1:0] slope_max;
   } cfg_type;

endpackage

>>> rtl/core/lssc_front.sv
// ----------------------------------------------------------------------------
// Lane segment slope classifier front end
// Accepts segments, forms deltas and signs, and queues them for the back end.
// ----------------------------------------------------------------------------
module lssc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lssc_pkg::COORD_BITS-1:0] req_x_start,
   input  logic [lssc_pkg::COORD_BITS-1:0] req_y_start,
   input  logic [lssc_pkg::COORD_BITS-1:0] req_x_end,
   input  logic [lssc_pkg::COORD_BITS-1:0] req_y_end,
   input  logic                           req_frame_start,
   output logic                           q_valid,
   input  logic                           q_pop,
   output lssc_pkg::seg_type              q_data
);
   import lssc_pkg::*;

   seg_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   seg_type           seg;
   logic              push;
   logic              x_lt;
   logic              y_lt;

   // Deltas are taken as magnitudes with a separate sign for the slope.
   always_comb begin
      x_lt = req_x_start < req_x_end;
      y_lt = req_y_start < req_y_end;
      seg.x_start     = req_x_start;
      seg.y_start     = req_y_start;
      seg.adx         = x_lt ? (req_x_end - req_x_start) : (req_x_start - req_x_end);
      seg.ady         = y_lt ? (req_y_end - req_y_start) : (req_y_start - req_y_end);
      seg.neg         = x_lt != y_lt;
      seg.vertical    = req_x_start == req_x_end;
      seg.frame_start = req_frame_start;
   end

   assign req_stall = cnt_ff == QCNT_W'(QDEPTH);
   assign push      = req_valid && !req_stall;
   assign q_valid   = cnt_ff != '0;
   assign q_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= seg;
      end
   end

endmodule

>>> rtl/core/lssc_back.sv
// ----------------------------------------------------------------------------
// Lane segment slope classifier back end
// Radix-2 slope divider, window test, intercept multiply and side counts.
// ----------------------------------------------------------------------------
module lssc_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lssc_pkg::cfg_type                    cfg,
   input  logic                                 q_valid,
   output logic                                 q_pop,
   input  lssc_pkg::seg_type                    q_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lssc_pkg::SIDE_W-1:0]          rsp_side,
   output logic signed [lssc_pkg::SLOPE_W-1:0]  rsp_slope,
   output logic signed [lssc_pkg::ICPT_W-1:0]   rsp_intercept,
   output logic [lssc_pkg::SLOT_W-1:0]          rsp_slot_index,
   output logic                                 rsp_list_full
);
   import lssc_pkg::*;

   localparam logic signed [K_W-1:0] SLOPE_HI = K_W'((2 ** (SLOPE_W - 1)) - 1);
   localparam logic signed [K_W-1:0] SLOPE_LO = -K_W'(2 ** (SLOPE_W - 1));
   localparam logic signed [ICPT_CALC_W-1:0] ICPT_HI =
      ICPT_CALC_W'((2 ** (ICPT_W - 1)) - 1);
   localparam logic signed [ICPT_CALC_W-1:0] ICPT_LO = -ICPT_CALC_W'(2 ** (ICPT_W - 1));

   back_state_type state_ff, state_in;
   seg_type        seg_ff, seg_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [DIV_W-1:0]      dvd_ff, dvd_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic signed [K_W-1:0]    k_ff, k_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   side_type               side_ff, side_in;
   logic [CNT_W-1:0]       left_ff, left_in;
   logic [CNT_W-1:0]       right_ff, right_in;

   logic                   out_valid_ff, out_valid_in;
   side_type               out_side_ff, out_side_in;
   logic signed [SLOPE_W-1:0] out_slope_ff, out_slope_in;
   logic signed [ICPT_W-1:0]  out_icpt_ff, out_icpt_in;
   logic [SLOT_W-1:0]      out_slot_ff, out_slot_in;
   logic                   out_full_ff, out_full_in;

   logic [COORD_BITS:0]    trial;
   logic [COORD_BITS:0]    diff;
   logic                   ge;
   logic                   in_range;
   logic [REG_W-1:0]       kmag;
   logic signed [K_W-1:0]  kpos;
   logic signed [ICPT_CALC_W-1:0] icpt;
   logic [CNT_W-1:0]       cnt_l;
   logic [CNT_W-1:0]       cnt_r;
   logic [CNT_W-1:0]       cnt_sel;
   logic                   out_free;

   // One quotient bit per cycle.
   always_comb begin
      trial = {rem_ff, dvd_ff[DIV_W-1]};
      diff  = trial - {1'b0, seg_ff.adx};
      ge    = trial >= {1'b0, seg_ff.adx};
   end

   always_comb begin
      in_range = !seg_ff.vertical && (quo_ff != '0)
                 && (quo_ff > DIV_W'(cfg.slope_min))
                 && (quo_ff < DIV_W'(cfg.slope_max));
      kmag = quo_ff[REG_W-1:0];
      kpos = $signed({1'b0, kmag});
   end

   always_comb begin
      icpt = $signed(ICPT_CALC_W'({seg_ff.y_start, {FRAC_BITS{1'b0}}}))
             - ICPT_CALC_W'(prod_ff);
      cnt_l = seg_ff.frame_start ? '0 : left_ff;
      cnt_r = seg_ff.frame_start ? '0 : right_ff;
      cnt_sel = (side_ff == SIDE_LEFT) ? cnt_l : cnt_r;
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvd_in   = dvd_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      prod_in  = prod_ff;
      side_in  = side_ff;
      left_in  = left_ff;
      right_in = right_ff;
      q_pop    = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_side_in  = out_side_ff;
      out_slope_in = out_slope_ff;
      out_icpt_in  = out_icpt_ff;
      out_slot_in  = out_slot_ff;
      out_full_in  = out_full_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               seg_in   = q_data;
               rem_in   = '0;
               quo_in   = '0;
               dvd_in   = {q_data.ady, {FRAC_BITS{1'b0}}};
               step_in  = STEP_W'(DIV_W - 1);
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            rem_in = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            quo_in = {quo_ff[DIV_W-2:0], ge};
            dvd_in = dvd_ff << 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            if (in_range) begin
               k_in    = seg_ff.neg ? -kpos : kpos;
               side_in = seg_ff.neg ? SIDE_LEFT : SIDE_RIGHT;
            end else begin
               k_in    = '0;
               side_in = SIDE_REJECT;
            end
            prod_in  = PROD_W'(k_in) * PROD_W'($signed({1'b0, seg_ff.x_start}));
            state_in = BK_FIN;
         end
         BK_FIN: begin
            if (out_free) begin
               left_in  = cnt_l;
               right_in = cnt_r;
               out_valid_in = 1'b1;
               out_side_in  = side_ff;
               out_slot_in  = '0;
               out_full_in  = 1'b0;
               if (side_ff == SIDE_REJECT) begin
                  out_slope_in = '0;
                  out_icpt_in  = '0;
               end else begin
                  if (k_ff > SLOPE_HI) begin
                     out_slope_in = SLOPE_HI[SLOPE_W-1:0];
                  end else if (k_ff < SLOPE_LO) begin
                     out_slope_in = SLOPE_LO[SLOPE_W-1:0];
                  end else begin
                     out_slope_in = k_ff[SLOPE_W-1:0];
                  end
                  if (icpt > ICPT_HI) begin
                     out_icpt_in = ICPT_HI[ICPT_W-1:0];
                  end else if (icpt < ICPT_LO) begin
                     out_icpt_in = ICPT_LO[ICPT_W-1:0];
                  end else begin
                     out_icpt_in = icpt[ICPT_W-1:0];
                  end
                  // A full list keeps its count; the segment still gets its slope.
                  if (cnt_sel >= CNT_W'(MAX_LINES)) begin
                     out_full_in = 1'b1;
                  end else begin
                     out_slot_in = cnt_sel[SLOT_W-1:0];
                     if (side_ff == SIDE_LEFT) begin
                        left_in = cnt_l + 1'b1;
                     end else begin
                        right_in = cnt_r + 1'b1;
                     end
                  end
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         left_ff      <= '0;
         right_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff       <= seg_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvd_ff       <= dvd_in;
      step_ff      <= step_in;
      k_ff         <= k_in;
      prod_ff      <= prod_in;
      side_ff      <= side_in;
      out_side_ff  <= out_side_in;
      out_slope_ff <= out_slope_in;
      out_icpt_ff  <= out_icpt_in;
      out_slot_ff  <= out_slot_in;
      out_full_ff  <= out_full_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_side       = out_side_ff;
   assign rsp_slope      = out_slope_ff;
   assign rsp_intercept  = out_icpt_ff;
   assign rsp_slot_index = out_slot_ff;
   assign rsp_list_full  = out_full_ff;

endmodule

>>> rtl/core/lane_segment_slope_classifier.sv
// ----------------------------------------------------------------------------
// Lane segment slope classifier
// Classifies line segments into left and right lane candidates by slope.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel carries one segment given by two endpoints.
// The block computes the slope dy/dx as a signed Q16 value truncated toward
// zero, rejects vertical segments and slopes outside the exclusive window set
// by the slope_min and slope_max registers, and returns exactly one transfer
// on the rsp_ channel per segment, in order. Negative slopes are left lane and
// positive slopes right lane; for these the block also returns the intercept
// and the next slot number of that side, whose count saturates at 128 and then
// raises list_full. A segment with frame_start set clears both counts first.
// In the back end a segment is taken from the queue, goes through the radix-2
// divider that produces one quotient bit per cycle and the intercept multiply,
// and is then loaded into the output register once that is free. The divider is the
// single shared unit, so a new segment is taken only once the previous one is loaded.
// A two-entry queue decouples input acceptance from the back end, and the
// output register lets the next segment be processed while a result waits.
// Registers sit at byte address 0 (slope_min) and 4 (slope_max); write them
// only while no segment is in flight.
// ----------------------------------------------------------------------------
module lane_segment_slope_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   // Segment input channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lssc_pkg::COORD_BITS-1:0]      req_x_start,
   input  logic [lssc_pkg::COORD_BITS-1:0]      req_y_start,
   input  logic [lssc_pkg::COORD_BITS-1:0]      req_x_end,
   input  logic [lssc_pkg::COORD_BITS-1:0]      req_y_end,
   input  logic                                 req_frame_start,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lssc_pkg::SIDE_W-1:0]          rsp_side,
   output logic signed [lssc_pkg::SLOPE_W-1:0]  rsp_slope,
   output logic signed [lssc_pkg::ICPT_W-1:0]   rsp_intercept,
   output logic [lssc_pkg::SLOT_W-1:0]          rsp_slot_index,
   output logic                                 rsp_list_full,
   // Register port.
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lssc_pkg::ADDR_W-1:0]          paddr,
   input  logic [lssc_pkg::DATA_W-1:0]          pwdata,
   output logic [lssc_pkg::DATA_W-1:0]          prdata,
   output logic                                 pready
);
   import lssc_pkg::*;

   logic [REG_W-1:0] slope_min_ff, slope_min_in;
   logic [REG_W-1:0] slope_max_ff, slope_max_in;
   logic             reg_write;
   logic             reg_sel;
   cfg_type          cfg;
   logic             q_valid;
   logic             q_pop;
   seg_type          q_data;

   // The register is picked by the word address bit; byte offset bits are ignored.
   assign pready    = 1'b1;
   assign reg_sel   = paddr[2];
   assign reg_write = psel && penable && pwrite && pready;

   always_comb begin
      slope_min_in = slope_min_ff;
      slope_max_in = slope_max_ff;
      if (reg_write) begin
         unique case (reg_sel)
            REG_SLOPE_MIN: slope_min_in = pwdata[REG_W-1:0];
            REG_SLOPE_MAX: slope_max_in = pwdata[REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SLOPE_MIN: prdata = DATA_W'(slope_min_ff);
         REG_SLOPE_MAX: prdata = DATA_W'(slope_max_ff);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_min_ff <= SLOPE_MIN_RESET;
         slope_max_ff <= SLOPE_MAX_RESET;
      end else begin
         slope_min_ff <= slope_min_in;
         slope_max_ff <= slope_max_in;
      end
   end

   assign cfg.slope_min = slope_min_ff;
   assign cfg.slope_max = slope_max_ff;

   // The front end takes segments and queues their deltas and signs.
   lssc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_frame_start (req_frame_start),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_data          (q_data)
   );

   // The back end divides, classifies, updates the side counts and
   // holds the result until the downstream side takes the transfer.
   lssc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_data         (q_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_side       (rsp_side),
      .rsp_slope      (rsp_slope),
      .rsp_intercept  (rsp_intercept),
      .rsp_slot_index (rsp_slot_index),
      .rsp_list_full  (rsp_list_full)
   );

endmodule
